>>> hw/rtl/vrsp_pkg.sv
// shared types and constants for the variable rate sample player
package vrsp_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int ADDR_BITS      = 16;
  localparam int STORE_DEPTH    = 1 << ADDR_BITS;
  localparam int RATE_FRAC_BITS = 16;
  localparam int HEAD_BITS      = 34;
  localparam int RATE_BITS      = 24;
  localparam int GAIN_BITS      = 16;
  localparam int FCOUNT_BITS    = 17;
  localparam int CHAN_BITS      = 2;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 24;

  // input item kinds
  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_REWIND = 2'd1,
    MODE_PLAY   = 2'd2
  } mode_t;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PLAY_RATE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PLAY_GAIN     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_COUNT   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd3;

  localparam logic [CHAN_BITS-1:0] CHAN_STEREO = 2'd2;

  // store write request
  typedef struct packed {
    logic                   en;
    logic [ADDR_BITS-1:0]   addr;
    logic [SAMPLE_BITS-1:0] data;
  } store_wr_t;

  // store read request, two addresses per frame
  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr0;
    logic [ADDR_BITS-1:0] addr1;
  } store_rd_t;

endpackage

>>> hw/rtl/vrsp_store.sv
// sample store: one write port, two registered read ports
module vrsp_store (
  input  logic                            clk,
  input  vrsp_pkg::store_wr_t             wr,
  input  vrsp_pkg::store_rd_t             rd,
  output logic [vrsp_pkg::SAMPLE_BITS-1:0] rd_data0,
  output logic [vrsp_pkg::SAMPLE_BITS-1:0] rd_data1
);
  import vrsp_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data0_r;
  logic [SAMPLE_BITS-1:0] rd_data1_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read ports, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data0_r <= mem[rd.addr0];
      rd_data1_r <= mem[rd.addr1];
    end
  end

  assign rd_data0 = rd_data0_r;
  assign rd_data1 = rd_data1_r;

endmodule

>>> hw/rtl/variable_rate_sample_player.sv
// top level of the variable rate sample player
//
// Input channel in_*: in_tuser carries the item kind (load, rewind, play),
// in_tdata the sample index, sample value and rewind frame. A load writes
// one sample into the 64k-entry store, a rewind moves the playhead to a
// whole frame, a play item reads the nearest frame and gives one result.
// Result channel out_*: left and right samples in out_tdata, end of data
// in out_tuser. Load and rewind items give no result.
// Configuration port cfg_*: rate, gain, frame count and channel count,
// always ready; the user must write it only while no item is in flight,
// as the block does not enforce this. Throughput: one item per cycle while
// the result channel does not stall. A play item passes the store read,
// multiplier and output registers before it shows on out_tvalid. When
// out_tready is low the stages fill one by one and in_tready falls only
// once every stage ahead holds an item; nothing is dropped.
// Reset clears the playhead and the pipeline valids and loads the default
// configuration; the store has undefined contents until written and needs
// no clearing pass, so items are accepted from the first cycle after reset.
module variable_rate_sample_player (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample_index [15:0], sample_value [31:16], rewind_frame [47:32]
  input  logic [47:0]                         in_tdata,
  // mode [1:0]
  input  logic [1:0]                          in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // left_sample [15:0], right_sample [31:16]
  output logic [31:0]                         out_tdata,
  // at_end [0]
  output logic [0:0]                          out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vrsp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [vrsp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import vrsp_pkg::*;

  // gain scaling with round to nearest and saturation
  function automatic logic [SAMPLE_BITS-1:0] scale_sat(input logic signed [31:0] p);
    logic signed [32:0] sum;
    logic        [20:0] hi;
    logic [SAMPLE_BITS-1:0] res;
    sum = {p[31], p} + 33'sd2048;
    hi  = sum[32:12];
    if (hi[20:15] == 6'b000000 || hi[20:15] == 6'b111111) begin
      res = hi[15:0];
    end else if (hi[20]) begin
      res = 16'h8000;
    end else begin
      res = 16'h7fff;
    end
    return res;
  endfunction

  // configuration registers
  logic signed [RATE_BITS-1:0]   rate_r;
  logic signed [GAIN_BITS-1:0]   gain_r;
  logic        [FCOUNT_BITS-1:0] fcount_r;
  logic        [CHAN_BITS-1:0]   chans_r;

  // playhead and pipeline registers
  logic signed [HEAD_BITS-1:0] head_r, head_nxt;
  logic                        v1_r, end1_r, st1_r;
  logic                        v2_r, end2_r, st2_r;
  logic signed [31:0]          prod0_r, prod1_r;
  logic                        out_valid_r;
  logic [31:0]                 out_data_r;
  logic                        out_end_r;

  // unpacked input fields
  logic [ADDR_BITS-1:0]   in_index;
  logic [SAMPLE_BITS-1:0] in_value;
  logic [15:0]            in_rewind;
  logic                   acc, is_load, is_rewind, is_play;
  logic                   en1, en2, en3;

  // frame selection
  logic signed [HEAD_BITS:0]   head_q;
  logic        [18:0]          frame_raw;
  logic        [FCOUNT_BITS-1:0] fcount_m1;
  logic        [15:0]          frame;
  logic        [HEAD_BITS-1:0] limit;
  logic                        at_end;
  logic                        stereo;

  store_wr_t              st_wr;
  store_rd_t              st_rd;
  logic [SAMPLE_BITS-1:0] rd0, rd1;

  assign in_index  = in_tdata[15:0];
  assign in_value  = in_tdata[31:16];
  assign in_rewind = in_tdata[47:32];

  // stage enables, bubbles collapse under backpressure
  assign en3       = !out_valid_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign acc       = in_tvalid && in_tready;
  assign is_load   = in_tuser == MODE_LOAD;
  assign is_rewind = in_tuser == MODE_REWIND;
  assign is_play   = in_tuser == MODE_PLAY;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= 24'sd65536;
      gain_r   <= 16'sd4096;
      fcount_r <= '0;
      chans_r  <= 2'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PLAY_RATE:     rate_r   <= cfg_data[RATE_BITS-1:0];
        CFG_PLAY_GAIN:     gain_r   <= cfg_data[GAIN_BITS-1:0];
        CFG_FRAME_COUNT:   fcount_r <= cfg_data[FCOUNT_BITS-1:0];
        CFG_CHANNEL_COUNT: chans_r  <= cfg_data[CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // nearest frame and end of data from the current playhead
  always_comb begin
    stereo    = chans_r == CHAN_STEREO;
    head_q    = {head_r[HEAD_BITS-1], head_r} + 35'sd32768;
    frame_raw = head_q[HEAD_BITS] ? '0 : head_q[HEAD_BITS:RATE_FRAC_BITS];
    fcount_m1 = fcount_r - 17'd1;
    if (fcount_r == '0) begin
      frame = '0;
    end else if (frame_raw >= {2'b00, fcount_r}) begin
      frame = fcount_m1[15:0];
    end else begin
      frame = frame_raw[15:0];
    end
    limit  = {1'b0, fcount_r, {RATE_FRAC_BITS{1'b0}}};
    at_end = rate_r[RATE_BITS-1] ? head_r[HEAD_BITS-1]
                                 : (head_r >= $signed(limit));
  end

  // playhead update
  always_comb begin
    head_nxt = head_r;
    if (acc && is_rewind) begin
      head_nxt = {2'b00, in_rewind, {RATE_FRAC_BITS{1'b0}}};
    end else if (acc && is_play && !at_end) begin
      head_nxt = head_r + {{(HEAD_BITS-RATE_BITS){rate_r[RATE_BITS-1]}}, rate_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  // store access
  always_comb begin
    st_wr.en    = acc && is_load;
    st_wr.addr  = in_index;
    st_wr.data  = in_value;
    st_rd.en    = en1;
    st_rd.addr0 = stereo ? {frame[14:0], 1'b0} : frame;
    st_rd.addr1 = {frame[14:0], 1'b1};
  end

  vrsp_store u_store (
    .clk      (clk),
    .wr       (st_wr),
    .rd       (st_rd),
    .rd_data0 (rd0),
    .rd_data1 (rd1)
  );

  // stage 1: store read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= acc && is_play;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      end1_r <= at_end;
      st1_r  <= stereo;
    end
  end

  // stage 2: gain multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      end2_r  <= end1_r;
      st2_r   <= st1_r;
      prod0_r <= $signed(rd0) * gain_r;
      prod1_r <= $signed(rd1) * gain_r;
    end
  end

  // stage 3: round, saturate, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_end_r        <= end2_r;
      out_data_r[15:0] <= end2_r ? '0 : scale_sat(prod0_r);
      out_data_r[31:16] <= (end2_r || !st2_r) ? '0 : scale_sat(prod1_r);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_end_r;

`ifndef NO_ASSERTIONS
  // only play items enter the result pipeline
  a_play_enters: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_play |=> v1_r)
    else $error("play item did not enter the pipeline");

  a_other_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !is_play |=> !v1_r)
    else $error("non-play item entered the pipeline");

  // playhead holds once the data has been left
  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_play && at_end |=> head_r == $past(head_r))
    else $error("playhead moved at end of data");

  // a rewind lands on a whole frame
  a_rewind_whole: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_rewind |=> head_r[RATE_FRAC_BITS-1:0] == '0)
    else $error("rewind left a fractional playhead");

  // end of data results carry silence
  a_end_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> out_data_r == '0)
    else $error("end of data result is not silent");
`endif

endmodule
